// ===== hdl/bscb_pkg.sv =====
// bscb_pkg: shared types and constants for the binary split team bitmap block
// used by bscb_ctrl, bscb_dp and binary_split_core_team_bitmap_unit
`timescale 1ns / 1ps

package bscb_pkg;

  localparam int unsigned CORE_COUNT = 64;

  localparam int unsigned ROOT_W  = 6;
  localparam int unsigned LEV_W   = 4;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned MAP_W   = 64;

  // pending groups have strictly falling levels from 4 down to -1
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic [ROOT_W-1:0]        root;
    logic signed [LEV_W-1:0]  lev;
    logic [COUNT_W-1:0]       cnt;
  } group_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic final_step;
  } dp_status_t;

endpackage

// ===== hdl/bscb_ctrl.sv =====
// bscb_ctrl: sequencer for the team bitmap block, handles both handshakes
// depends on bscb_pkg
`timescale 1ns / 1ps

module bscb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  bscb_pkg::dp_status_t  status_i,
  output bscb_pkg::dp_cmd_t     cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.load    = in_valid_i && (state_q == ST_IDLE);
    cmd_o.step    = (state_q == ST_RUN) && out_free;
    cmd_o.publish = cmd_o.step && status_i.final_step;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cmd_o.publish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.publish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/bscb_dp.sv =====
// bscb_dp: current group registers, pending group stack, bitmap and result registers
// depends on bscb_pkg
`timescale 1ns / 1ps

module bscb_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bscb_pkg::dp_cmd_t                     cmd_i,
  output bscb_pkg::dp_status_t                  status_o,
  input  logic [bscb_pkg::ROOT_W-1:0]           root_core_i,
  input  logic signed [bscb_pkg::LEV_W-1:0]     split_level_i,
  input  logic [bscb_pkg::COUNT_W-1:0]          thread_count_i,
  output logic [bscb_pkg::MAP_W-1:0]            core_map_o,
  output logic                                  placement_error_o
);

  localparam int unsigned CHILD_W = bscb_pkg::ROOT_W + 3;

  bscb_pkg::group_t cur_q;
  bscb_pkg::group_t stack_q [bscb_pkg::STACK_DEPTH];
  logic [bscb_pkg::SP_W:0]       sp_q;
  logic [bscb_pkg::SP_W:0]       sp_dec;
  logic [bscb_pkg::MAP_W-1:0]    bm_q, bm_d;
  logic [bscb_pkg::MAP_W-1:0]    core_map_q;
  logic                          placement_error_q;

  logic                          is_leaf, lev_neg, child_bad, root_bad, err;
  logic [CHILD_W-2:0]            pow;
  logic [CHILD_W-1:0]            child;
  logic [bscb_pkg::COUNT_W:0]    cnt_inc;
  logic [bscb_pkg::COUNT_W-1:0]  keep, send;
  logic signed [bscb_pkg::LEV_W-1:0] lev_next;

  assign sp_dec  = sp_q - 1'b1;
  assign is_leaf = (cur_q.cnt <= bscb_pkg::COUNT_W'(1));
  assign lev_neg = cur_q.lev[bscb_pkg::LEV_W-1];
  assign pow     = (CHILD_W-1)'(1) << cur_q.lev[2:0];
  assign child   = {3'b000, cur_q.root} + {1'b0, pow};
  assign child_bad = (child >= CHILD_W'(bscb_pkg::CORE_COUNT));
  assign root_bad  = ({1'b0, cur_q.root} >= (bscb_pkg::ROOT_W+1)'(bscb_pkg::CORE_COUNT));
  assign err       = is_leaf ? root_bad : (lev_neg || child_bad);
  assign cnt_inc   = {1'b0, cur_q.cnt} + 1'b1;
  assign keep      = cnt_inc[bscb_pkg::COUNT_W:1];
  assign send      = cur_q.cnt - keep;
  assign lev_next  = cur_q.lev - 4'sd1;

  assign status_o.final_step = err || (is_leaf && (sp_q == '0));

  always_comb begin
    bm_d = bm_q;
    if (is_leaf && !err) bm_d = bm_q | (bscb_pkg::MAP_W'(1) << cur_q.root);
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q.root <= root_core_i;
      cur_q.lev  <= split_level_i;
      cur_q.cnt  <= thread_count_i;
      bm_q       <= '0;
    end else if (cmd_i.step) begin
      bm_q <= bm_d;
      if (is_leaf) begin
        if (sp_q != '0) cur_q <= stack_q[sp_dec[bscb_pkg::SP_W-1:0]];
      end else begin
        stack_q[sp_q[bscb_pkg::SP_W-1:0]] <= '{root: child[bscb_pkg::ROOT_W-1:0],
                                               lev: lev_next, cnt: send};
        cur_q.lev <= lev_next;
        cur_q.cnt <= keep;
      end
    end
    if (cmd_i.publish) begin
      core_map_q        <= err ? '0 : bm_d;
      placement_error_q <= err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.load) begin
      sp_q <= '0;
    end else if (cmd_i.step && !err) begin
      if (is_leaf) begin
        if (sp_q != '0) sp_q <= sp_dec;
      end else begin
        sp_q <= sp_q + 1'b1;
      end
    end
  end

  assign core_map_o        = core_map_q;
  assign placement_error_o = placement_error_q;

endmodule

// ===== hdl/binary_split_core_team_bitmap_unit.sv =====
// binary_split_core_team_bitmap_unit: top level of the team bitmap block
// depends on bscb_pkg, bscb_ctrl and bscb_dp
//
// usage: one input beat (root_core_i, split_level_i, thread_count_i) yields one
// output beat (core_map_o, placement_error_o). both channels are valid/stall:
// a beat moves on a rising edge with valid high and stall low.
// the input beat loads a work register; each cycle one group of threads is
// handled: a group of two or more splits, its upper half goes on an 8-deep
// stack of pending groups, a group of one or zero marks its core in the bitmap
// and the next group is popped. out_valid_o rises when the last group has
// been handled, and the run ends at once on an error (negative split level,
// core index past the end), which gives a zero bitmap. in_stall_o stays high
// until the result is loaded into the output register, so a new item is taken
// only after the last one is through. while the output register is full and
// the receiver stalls, stepping of the next item pauses until it drains.
// reset empties the output register and returns to waiting for an input beat;
// no state is kept between items.
`timescale 1ns / 1ps

module binary_split_core_team_bitmap_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bscb_pkg::ROOT_W-1:0]         root_core_i,
  input  logic signed [bscb_pkg::LEV_W-1:0]   split_level_i,
  input  logic [bscb_pkg::COUNT_W-1:0]        thread_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bscb_pkg::MAP_W-1:0]          core_map_o,
  output logic                                placement_error_o
);

  bscb_pkg::dp_cmd_t    cmd;
  bscb_pkg::dp_status_t status;

  bscb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bscb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .root_core_i       (root_core_i),
    .split_level_i     (split_level_i),
    .thread_count_i    (thread_count_i),
    .core_map_o        (core_map_o),
    .placement_error_o (placement_error_o)
  );

endmodule

// ===== tb/tb_binary_split_core_team_bitmap_unit.sv =====
// tb_binary_split_core_team_bitmap_unit: self-checking bench for the team bitmap unit
// drives directed and random beats, predicts each bitmap not typed into a directed row
// by recursive halving, compares every output beat in order; needs bscb_pkg and the DUT
`timescale 1ns / 1ps

module tb_binary_split_core_team_bitmap_unit;

  localparam int unsigned RANDOM_ITEMS = 1630;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 260;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct {
    logic [bscb_pkg::MAP_W-1:0] map;
    logic                       err;
  } team_result_t;

  typedef struct {
    logic [bscb_pkg::ROOT_W-1:0]       root;
    logic signed [bscb_pkg::LEV_W-1:0] lev;
    logic [bscb_pkg::COUNT_W-1:0]      cnt;
    bit                                typed;
    logic [bscb_pkg::MAP_W-1:0]        map;
    logic                              err;
  } dir_row_t;

  logic                              clk_i;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic [bscb_pkg::ROOT_W-1:0]       root_core_i    = '0;
  logic signed [bscb_pkg::LEV_W-1:0] split_level_i  = '0;
  logic [bscb_pkg::COUNT_W-1:0]      thread_count_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic [bscb_pkg::MAP_W-1:0]        core_map_o;
  logic                              placement_error_o;

  team_result_t team_expect_q[$];
  dir_row_t     dir_rows[$];
  int unsigned  error_count     = 0;
  int unsigned  results_checked = 0;
  int unsigned  error_results   = 0;
  int unsigned  items_sent      = 0;
  int unsigned  send_idle_pct   = 35;
  int unsigned  recv_idle_pct   = 63;
  int unsigned  quiet_cycles    = 0;

  binary_split_core_team_bitmap_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .root_core_i       (root_core_i),
    .split_level_i     (split_level_i),
    .thread_count_i    (thread_count_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .core_map_o        (core_map_o),
    .placement_error_o (placement_error_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // any failing group poisons the whole team, so the order groups are walked in is free
  function automatic team_result_t predict_team(input logic [bscb_pkg::ROOT_W-1:0] root,
                                                input logic signed [bscb_pkg::LEV_W-1:0] lev,
                                                input logic [bscb_pkg::COUNT_W-1:0] cnt);
    team_result_t res;
    int unsigned  pend_root[$];
    int           pend_lev[$];
    int unsigned  pend_cnt[$];
    int unsigned  r;
    int           l;
    int unsigned  n;
    int unsigned  keep;
    int unsigned  child;
    bit           bad;
    res.map = '0;
    bad = 1'b0;
    pend_root.push_back(32'(root));
    l = int'(lev);
    pend_lev.push_back(l);
    pend_cnt.push_back(32'(cnt));
    while (pend_root.size() != 0 && !bad) begin
      r = pend_root.pop_back();
      l = pend_lev.pop_back();
      n = pend_cnt.pop_back();
      while (n > 1 && !bad) begin
        keep = (n + 1) >> 1;
        if (l < 0) begin
          bad = 1'b1;
        end else begin
          child = r + (1 << l);
          if (child >= bscb_pkg::CORE_COUNT) begin
            bad = 1'b1;
          end else begin
            pend_root.push_back(child);
            pend_lev.push_back(l - 1);
            pend_cnt.push_back(n - keep);
            l = l - 1;
            n = keep;
          end
        end
      end
      if (!bad) begin
        if (r >= bscb_pkg::CORE_COUNT) bad = 1'b1;
        else res.map = res.map | (64'd1 << r);
      end
    end
    if (bad) res.map = '0;
    res.err = bad;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [bscb_pkg::MAP_W-1:0] got,
                                 input logic [bscb_pkg::MAP_W-1:0] want);
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
    error_count++;
  endtask

  task automatic add_row(input logic [bscb_pkg::ROOT_W-1:0] root,
                         input logic signed [bscb_pkg::LEV_W-1:0] lev,
                         input logic [bscb_pkg::COUNT_W-1:0] cnt, input bit typed,
                         input logic [bscb_pkg::MAP_W-1:0] map, input logic err);
    dir_row_t row;
    row.root  = root;
    row.lev   = lev;
    row.cnt   = cnt;
    row.typed = typed;
    row.map   = map;
    row.err   = err;
    dir_rows.push_back(row);
  endtask

  // one beat out; the expectation is queued at the edge the beat is taken
  task automatic send_team(input logic [bscb_pkg::ROOT_W-1:0] root,
                           input logic signed [bscb_pkg::LEV_W-1:0] lev,
                           input logic [bscb_pkg::COUNT_W-1:0] cnt, input team_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    root_core_i    <= root;
    split_level_i  <= lev;
    thread_count_i <= cnt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    team_expect_q.push_back(want);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (team_expect_q.size() == 0) begin
          report_mismatch("unexpected result beat", core_map_o, '0);
        end else begin
          team_result_t want;
          want = team_expect_q.pop_front();
          if (core_map_o !== want.map)
            report_mismatch("core_map", core_map_o, want.map);
          if (placement_error_o !== want.err)
            report_mismatch("placement_error", bscb_pkg::MAP_W'(placement_error_o),
                            bscb_pkg::MAP_W'(want.err));
          results_checked++;
          if (want.err) error_results++;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // counts cycles with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 35;
        recv_idle_pct = 63;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 63;
        recv_idle_pct = 35;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    team_result_t                      want;
    logic [bscb_pkg::ROOT_W-1:0]       root;
    logic signed [bscb_pkg::LEV_W-1:0] lev;
    logic [bscb_pkg::COUNT_W-1:0]      cnt;
    int unsigned                       span;
    int unsigned                       dir_count;

    // lone threads, negative levels, cores past the end, full and oversized teams
    add_row(6'd0,  -4'sd1, 7'd1,   1, 64'd1, 1'b0);
    add_row(6'd63, -4'sd1, 7'd0,   1, 64'h8000_0000_0000_0000, 1'b0);
    add_row(6'd0,  -4'sd1, 7'd2,   1, 64'd0, 1'b1);
    add_row(6'd0,  -4'sd8, 7'd2,   1, 64'd0, 1'b1);
    add_row(6'd5,  -4'sd8, 7'd1,   1, 64'h20, 1'b0);
    add_row(6'd0,  4'sd0,  7'd2,   1, 64'd3, 1'b0);
    add_row(6'd63, 4'sd0,  7'd2,   1, 64'd0, 1'b1);
    add_row(6'd0,  4'sd5,  7'd64,  1, '1, 1'b0);
    add_row(6'd1,  4'sd5,  7'd64,  1, 64'd0, 1'b1);
    add_row(6'd0,  4'sd5,  7'd65,  1, 64'd0, 1'b1);
    add_row(6'd0,  4'sd7,  7'd127, 1, 64'd0, 1'b1);
    add_row(6'd0,  4'sd6,  7'd2,   1, 64'd0, 1'b1);
    add_row(6'd0,  4'sd6,  7'd1,   1, 64'd1, 1'b0);
    add_row(6'd0,  4'sd7,  7'd0,   1, 64'd1, 1'b0);
    add_row(6'd32, 4'sd4,  7'd32,  1, 64'hFFFF_FFFF_0000_0000, 1'b0);
    add_row(6'd48, 4'sd3,  7'd16,  1, 64'hFFFF_0000_0000_0000, 1'b0);
    add_row(6'd63, 4'sd5,  7'd1,   1, 64'h8000_0000_0000_0000, 1'b0);
    add_row(6'd21, -4'sd1, 7'd127, 1, 64'd0, 1'b1);
    add_row(6'd0,  4'sd4,  7'd33,  0, '0, 1'b0);
    add_row(6'd0,  4'sd2,  7'd5,   0, '0, 1'b0);
    add_row(6'd10, 4'sd3,  7'd7,   0, '0, 1'b0);
    add_row(6'd0,  4'sd0,  7'd3,   0, '0, 1'b0);
    add_row(6'd7,  4'sd1,  7'd4,   0, '0, 1'b0);
    add_row(6'd42, 4'sd2,  7'd6,   0, '0, 1'b0);
    dir_count = dir_rows.size();

    set_idle(IDLE_SEND_LIGHT);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        want.map = dir_rows[i].map;
        want.err = dir_rows[i].err;
      end else begin
        want = predict_team(dir_rows[i].root, dir_rows[i].lev, dir_rows[i].cnt);
      end
      send_team(dir_rows[i].root, dir_rows[i].lev, dir_rows[i].cnt, want);
    end

    for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) set_idle(IDLE_SEND_HEAVY);
      if (k == 2 * RANDOM_ITEMS / 3) set_idle(IDLE_NONE);
      if ($urandom_range(99) < 75) begin
        // team that fits: root leaves room for the whole split tree
        lev  = bscb_pkg::LEV_W'($urandom_range(5));
        span = 1 << (lev + 1);
        cnt  = bscb_pkg::COUNT_W'($urandom_range(span));
        root = bscb_pkg::ROOT_W'($urandom_range(bscb_pkg::CORE_COUNT - span));
      end else begin
        root = bscb_pkg::ROOT_W'($urandom_range(bscb_pkg::CORE_COUNT - 1));
        lev  = bscb_pkg::LEV_W'($urandom_range(15));
        cnt  = bscb_pkg::COUNT_W'($urandom_range(127));
      end
      send_team(root, lev, cnt, predict_team(root, lev, cnt));
    end
    in_valid_i <= 1'b0;

    while (team_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d team requests (%0d directed), checked %0d results, %0d placement errors",
             items_sent, dir_count, results_checked, error_results);
    $display("idle patterns: sender light, sender heavy, none; mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
